// ----- hdl/bts_pkg.sv -----
// ----------------------------------------------------------------------------
// bts_pkg
// Shared types and constants of the binary trie set engine: operation codes,
// payload widths and the controller state encoding.
// ----------------------------------------------------------------------------
package bts_pkg;

   // Payload widths of the request channel.
   localparam int unsigned OP_W  = 2;
   localparam int unsigned KEY_W = 32;

   // Operation codes carried in the request payload. Code 3 is a no-op.
   localparam logic [OP_W-1:0] OP_SEARCH = 2'd0;
   localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_STEP,
      ST_FILL,
      ST_DONE
   } state_type;

endpackage

// ----- hdl/bts_req_if.sv -----
// ----------------------------------------------------------------------------
// bts_req_if
// Request channel: valid/ready handshake carrying an operation and a key.
// ----------------------------------------------------------------------------
interface bts_req_if;
   logic                      valid;
   logic                      ready;
   logic [bts_pkg::OP_W-1:0]  operation;
   logic [bts_pkg::KEY_W-1:0] key;

   modport source (output valid, output operation, output key, input ready);
   modport sink   (input valid, input operation, input key, output ready);
endinterface

// ----- hdl/bts_rsp_if.sv -----
// ----------------------------------------------------------------------------
// bts_rsp_if
// Response channel: valid/ready handshake carrying the hit and pool-full flags.
// ----------------------------------------------------------------------------
interface bts_rsp_if;
   logic valid;
   logic ready;
   logic hit;
   logic pool_full;

   modport source (output valid, output hit, output pool_full, input ready);
   modport sink   (input valid, input hit, input pool_full, output ready);
endinterface

// ----- hdl/bts_node_ram.sv -----
// ----------------------------------------------------------------------------
// bts_node_ram
// Node pool memory: one write port and one read port with registered read
// data. The read data holds its value until the next read.
// ----------------------------------------------------------------------------
module bts_node_ram #(
   parameter int unsigned DEPTH  = 1024,
   parameter int unsigned ADDR_W = 10,
   parameter int unsigned WIDTH  = 21
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data
);

   logic [WIDTH-1:0] node_mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         node_mem[wr_addr] <= wr_data;
      end
   end

   // Read port with registered read data.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= node_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/binary_trie_set_engine_core.sv -----
// ----------------------------------------------------------------------------
// binary_trie_set_engine_core
// Keeps a set of keys as a binary trie in a node pool memory. Keys are walked
// least significant bit first up to their highest set bit. Supports search,
// insert with pool overflow detection, and clear.
//
//   Channel  Direction  Transfer payload
//   req_     in         operation (2 bits), key (32 bits)
//   rsp_     out        hit (1 bit), pool_full (1 bit)
//
// A search walks at most len levels, where len is the key's path length
// (highest set bit + 1), and fewer when the walk meets a missing child. An
// insert walks every level, each either read from the node memory or written
// as a new node, one per cycle; a refused insert stops before its writes.
// Clear and the unused code go straight to the response. Reset is synchronous
// and needs no clearing pass: the pool is tracked by its allocation count. A
// stalled response holds in its output register while the next request is
// accepted; the following result waits until that register is free.
// ----------------------------------------------------------------------------
module binary_trie_set_engine_core #(
   parameter int unsigned KEY_BITS   = 32,
   parameter int unsigned NODE_COUNT = 1024
) (
   input logic         clock,
   input logic         reset,
   bts_req_if.sink     req_chan,
   bts_rsp_if.source   rsp_chan
);

   localparam int unsigned IDX_W  = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
   localparam int unsigned NW     = IDX_W + 1;
   localparam int unsigned LEN_W  = $clog2(KEY_BITS + 1);
   localparam int unsigned CW     = (LEN_W > NW) ? LEN_W : NW;
   localparam int unsigned NODE_W = 2 * IDX_W + 1;
   localparam int unsigned CP     = (KEY_BITS < bts_pkg::KEY_W) ? KEY_BITS : bts_pkg::KEY_W;

   bts_pkg::state_type state_ff, state_in;

   logic [bts_pkg::OP_W-1:0] op_ff, op_in;
   logic [KEY_BITS-1:0]      rem_ff, rem_in;
   logic [LEN_W-1:0]         len_ff, len_in;
   logic [LEN_W-1:0]         depth_ff, depth_in;
   logic [IDX_W-1:0]         cur_idx_ff, cur_idx_in;
   logic [NW-1:0]            nf_ff, nf_in;
   logic [IDX_W-1:0]         root_zero_ff, root_zero_in;
   logic [IDX_W-1:0]         root_one_ff, root_one_in;
   logic                     root_end_ff, root_end_in;
   logic                     res_hit_ff, res_hit_in;
   logic                     res_full_ff, res_full_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_hit_ff, rsp_hit_in;
   logic                     rsp_full_ff, rsp_full_in;

   logic                     req_xfer;
   logic                     rsp_free;
   logic [KEY_BITS-1:0]      key_m;
   logic [LEN_W-1:0]         len_calc;

   logic                     ram_rd_en;
   logic [IDX_W-1:0]         ram_rd_addr;
   logic [NODE_W-1:0]        ram_rd_data;
   logic                     ram_wr_en;
   logic [IDX_W-1:0]         ram_wr_addr;
   logic [NODE_W-1:0]        ram_wr_data;

   logic [IDX_W-1:0]         cur_zero;
   logic [IDX_W-1:0]         cur_one;
   logic                     cur_end;
   logic [IDX_W-1:0]         child;
   logic                     at_end;
   logic [CW-1:0]            needed;
   logic [CW-1:0]            avail;
   logic                     no_room;
   logic [IDX_W-1:0]         nf_idx;
   logic [IDX_W-1:0]         nf_next_idx;

   // Node pool.
   bts_node_ram #(
      .DEPTH  (NODE_COUNT),
      .ADDR_W (IDX_W),
      .WIDTH  (NODE_W)
   ) u_node_ram (
      .clock   (clock),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data)
   );

   // Handshakes.
   assign req_xfer = req_chan.valid && req_chan.ready;
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;

   assign req_chan.ready     = (state_ff == bts_pkg::ST_IDLE);
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.hit       = rsp_hit_ff;
   assign rsp_chan.pool_full = rsp_full_ff;

   // Key restricted to the configured width and its path length.
   assign key_m = KEY_BITS'(req_chan.key[CP-1:0]);

   always_comb begin
      len_calc = LEN_W'(1);
      for (int i = 1; i < KEY_BITS; i++) begin
         if (key_m[i]) begin
            len_calc = LEN_W'(i + 1);
         end
      end
   end

   // Current node: the root lives in registers, other nodes come from the read port.
   assign cur_zero = (cur_idx_ff == '0) ? root_zero_ff : ram_rd_data[IDX_W:1];
   assign cur_one  = (cur_idx_ff == '0) ? root_one_ff  : ram_rd_data[NODE_W-1:IDX_W+1];
   assign cur_end  = (cur_idx_ff == '0) ? root_end_ff  : ram_rd_data[0];
   assign child    = rem_ff[0] ? cur_one : cur_zero;
   assign at_end   = (depth_ff == len_ff);

   // Free node check for an insert.
   assign needed      = CW'(len_ff) - CW'(depth_ff);
   assign avail       = CW'(NW'(NODE_COUNT) - nf_ff);
   assign no_room     = (needed > avail);
   assign nf_idx      = nf_ff[IDX_W-1:0];
   assign nf_next_idx = nf_idx + IDX_W'(1);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bts_pkg::ST_IDLE: begin
            if (req_xfer) begin
               if (req_chan.operation == bts_pkg::OP_SEARCH ||
                   req_chan.operation == bts_pkg::OP_INSERT) begin
                  state_in = bts_pkg::ST_STEP;
               end else begin
                  state_in = bts_pkg::ST_DONE;
               end
            end
         end
         bts_pkg::ST_STEP: begin
            if (at_end || child == '0) begin
               if (op_ff == bts_pkg::OP_INSERT && !at_end && !no_room) begin
                  state_in = bts_pkg::ST_FILL;
               end else begin
                  state_in = bts_pkg::ST_DONE;
               end
            end
         end
         bts_pkg::ST_FILL: begin
            if (at_end) begin
               state_in = bts_pkg::ST_DONE;
            end
         end
         bts_pkg::ST_DONE: begin
            if (rsp_free) begin
               state_in = bts_pkg::ST_IDLE;
            end
         end
         default: state_in = bts_pkg::ST_IDLE;
      endcase
   end

   // Datapath, memory controls and result.
   always_comb begin
      op_in        = op_ff;
      rem_in       = rem_ff;
      len_in       = len_ff;
      depth_in     = depth_ff;
      cur_idx_in   = cur_idx_ff;
      nf_in        = nf_ff;
      root_zero_in = root_zero_ff;
      root_one_in  = root_one_ff;
      root_end_in  = root_end_ff;
      res_hit_in   = res_hit_ff;
      res_full_in  = res_full_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_hit_in   = rsp_hit_ff;
      rsp_full_in  = rsp_full_ff;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = child;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = cur_idx_ff;
      ram_wr_data  = {cur_one, cur_zero, cur_end};

      unique case (state_ff)
         bts_pkg::ST_IDLE: begin
            // Latch the request; a clear empties the set right away.
            if (req_xfer) begin
               op_in       = req_chan.operation;
               rem_in      = key_m;
               len_in      = len_calc;
               depth_in    = '0;
               cur_idx_in  = '0;
               res_hit_in  = 1'b0;
               res_full_in = 1'b0;
               if (req_chan.operation == bts_pkg::OP_CLEAR) begin
                  root_zero_in = '0;
                  root_one_in  = '0;
                  root_end_in  = 1'b0;
                  nf_in        = NW'(1);
               end
            end
         end
         bts_pkg::ST_STEP: begin
            if (!at_end && child != '0) begin
               // Existing child: descend one level.
               ram_rd_en  = 1'b1;
               cur_idx_in = child;
               rem_in     = rem_ff >> 1;
               depth_in   = depth_ff + LEN_W'(1);
            end else if (op_ff == bts_pkg::OP_SEARCH) begin
               res_hit_in = at_end && cur_end;
            end else if (no_room) begin
               res_full_in = 1'b1;
            end else begin
               // Update the last existing node: mark it or link the first new node.
               if (at_end) begin
                  res_hit_in = !cur_end;
                  ram_wr_data = {cur_one, cur_zero, 1'b1};
               end else begin
                  res_hit_in = 1'b1;
                  rem_in     = rem_ff >> 1;
                  depth_in   = depth_ff + LEN_W'(1);
                  if (rem_ff[0]) begin
                     ram_wr_data = {nf_idx, cur_zero, cur_end};
                  end else begin
                     ram_wr_data = {cur_one, nf_idx, cur_end};
                  end
               end
               if (cur_idx_ff == '0) begin
                  root_one_in  = ram_wr_data[NODE_W-1:IDX_W+1];
                  root_zero_in = ram_wr_data[IDX_W:1];
                  root_end_in  = ram_wr_data[0];
               end else begin
                  ram_wr_en = 1'b1;
               end
            end
         end
         bts_pkg::ST_FILL: begin
            // Write one freshly allocated node per cycle.
            ram_wr_en   = 1'b1;
            ram_wr_addr = nf_idx;
            nf_in       = nf_ff + NW'(1);
            if (at_end) begin
               ram_wr_data = {{IDX_W{1'b0}}, {IDX_W{1'b0}}, 1'b1};
            end else begin
               rem_in   = rem_ff >> 1;
               depth_in = depth_ff + LEN_W'(1);
               if (rem_ff[0]) begin
                  ram_wr_data = {nf_next_idx, {IDX_W{1'b0}}, 1'b0};
               end else begin
                  ram_wr_data = {{IDX_W{1'b0}}, nf_next_idx, 1'b0};
               end
            end
         end
         bts_pkg::ST_DONE: begin
            // Move the result into the output register once it is free.
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = res_hit_ff;
               rsp_full_in  = res_full_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bts_pkg::ST_IDLE;
         nf_ff        <= NW'(1);
         root_zero_ff <= '0;
         root_one_ff  <= '0;
         root_end_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         nf_ff        <= nf_in;
         root_zero_ff <= root_zero_in;
         root_one_ff  <= root_one_in;
         root_end_ff  <= root_end_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      rem_ff      <= rem_in;
      len_ff      <= len_in;
      depth_ff    <= depth_in;
      cur_idx_ff  <= cur_idx_in;
      res_hit_ff  <= res_hit_in;
      res_full_ff <= res_full_in;
      rsp_hit_ff  <= rsp_hit_in;
      rsp_full_ff <= rsp_full_in;
   end

   // The allocation pointer stays within the pool and never points at slot zero.
   a_nf_range: assert property (@(posedge clock) disable iff (reset)
      (nf_ff != '0) && (nf_ff <= NW'(NODE_COUNT)))
      else $error("allocation pointer out of range");

   // A walk never goes past the key's path length.
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bts_pkg::ST_STEP || state_ff == bts_pkg::ST_FILL) |-> (depth_ff <= len_ff))
      else $error("walk depth beyond path length");

   // New nodes are only written while free slots remain.
   a_fill_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bts_pkg::ST_FILL) |-> (nf_ff < NW'(NODE_COUNT)))
      else $error("node fill past end of pool");

   // An accepted request always leaves the idle state.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff != bts_pkg::ST_IDLE))
      else $error("request accepted without starting work");

endmodule
